// ===== rtl/bresenham_line_points_macros.svh =====
`ifndef BRESENHAM_LINE_POINTS_MACROS_SVH
`define BRESENHAM_LINE_POINTS_MACROS_SVH

// Checked on every edge outside reset.
`define BLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define BLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/blp_pkg.sv =====
package blp_pkg;

  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 3;
  localparam int EXT_BITS   = ERR_BITS + 1;
  localparam int CNT_BITS   = COORD_BITS + 1;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_NEXT  = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
  } blp_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic                  last_pixel;
    logic                  pixel_valid;
  } blp_pix_t;

  // step_directions: bit0 major axis walks down, bit1 minor axis steps down
  typedef struct packed {
    logic                       line_active;
    logic [COORD_BITS-1:0]      cur_x;
    logic [COORD_BITS-1:0]      cur_y;
    logic signed [ERR_BITS-1:0] error_term;
    logic [COORD_BITS-1:0]      abs_delta_x;
    logic [COORD_BITS-1:0]      abs_delta_y;
    logic                       steep_flag;
    logic [1:0]                 step_directions;
    logic [CNT_BITS-1:0]        pixels_left;
  } blp_state_t;

endpackage

// ===== rtl/blp_setup.sv =====
module blp_setup (
  input  blp_pkg::blp_req_t   req,
  output blp_pkg::blp_state_t st,
  output blp_pkg::blp_pix_t   pix
);
  import blp_pkg::*;

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      adx;
  logic [COORD_BITS-1:0]      ady;
  logic [COORD_BITS-1:0]      big;
  logic [COORD_BITS-1:0]      small_d;
  logic                       steep;
  logic signed [ERR_BITS-1:0] small2;
  logic signed [ERR_BITS-1:0] big1;

  always_comb begin
    dx     = signed'({1'b0, req.x_end}) - signed'({1'b0, req.x_start});
    dy     = signed'({1'b0, req.y_end}) - signed'({1'b0, req.y_start});
    adx    = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ady    = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    steep  = !(ady < adx);
    big    = steep ? ady : adx;
    small_d = steep ? adx : ady;
    small2 = signed'(ERR_BITS'({small_d, 1'b0}));
    big1   = signed'(ERR_BITS'(big));

    st.line_active     = (big != '0);
    st.cur_x           = req.x_start;
    st.cur_y           = req.y_start;
    st.error_term      = small2 - big1;
    st.abs_delta_x     = adx;
    st.abs_delta_y     = ady;
    st.steep_flag      = steep;
    st.step_directions = {(steep ? dx[COORD_BITS] : dy[COORD_BITS]),
                          (steep ? dy[COORD_BITS] : dx[COORD_BITS])};
    st.pixels_left     = CNT_BITS'(big);

    pix.pixel_x     = req.x_start;
    pix.pixel_y     = req.y_start;
    pix.last_pixel  = (big == '0);
    pix.pixel_valid = 1'b1;
  end

endmodule

// ===== rtl/blp_walk.sv =====
module blp_walk (
  input  blp_pkg::blp_state_t cur,
  output blp_pkg::blp_state_t nxt,
  output blp_pkg::blp_pix_t   pix
);
  import blp_pkg::*;

  logic [COORD_BITS-1:0]      big;
  logic [COORD_BITS-1:0]      small_d;
  logic signed [EXT_BITS-1:0] e_w;
  logic signed [EXT_BITS-1:0] big2;
  logic signed [EXT_BITS-1:0] small2;
  logic signed [EXT_BITS-1:0] a;
  logic signed [EXT_BITS-1:0] e_new;
  logic                       reverse;
  logic                       min_down;
  logic                       minor_step;
  logic [COORD_BITS-1:0]      maj;
  logic [COORD_BITS-1:0]      mnr;
  logic [COORD_BITS-1:0]      maj_next;
  logic [COORD_BITS-1:0]      mnr_next;
  logic [CNT_BITS-1:0]        left_next;

  always_comb begin
    big      = cur.steep_flag ? cur.abs_delta_y : cur.abs_delta_x;
    small_d  = cur.steep_flag ? cur.abs_delta_x : cur.abs_delta_y;
    e_w      = EXT_BITS'(cur.error_term);
    big2     = signed'(EXT_BITS'({big, 1'b0}));
    small2   = signed'(EXT_BITS'({small_d, 1'b0}));
    reverse  = cur.step_directions[0];
    min_down = cur.step_directions[1];
    a        = e_w - small2;

    if (!reverse) begin
      minor_step = (e_w > 0);
      e_new = minor_step ? e_w - big2 + small2 : e_w + small2;
    end else begin
      // undo one forward update: the two outcomes fall in disjoint ranges
      minor_step = !(a > small2 - big2);
      e_new = minor_step ? a + big2 : a;
    end

    maj      = cur.steep_flag ? cur.cur_y : cur.cur_x;
    mnr      = cur.steep_flag ? cur.cur_x : cur.cur_y;
    maj_next = reverse ? maj - 1'b1 : maj + 1'b1;
    mnr_next = minor_step ? (min_down ? mnr - 1'b1 : mnr + 1'b1) : mnr;
    left_next = cur.pixels_left - 1'b1;

    nxt = cur;
    pix = '0;
    if (cur.line_active) begin
      nxt.cur_x       = cur.steep_flag ? mnr_next : maj_next;
      nxt.cur_y       = cur.steep_flag ? maj_next : mnr_next;
      nxt.error_term  = ERR_BITS'(e_new);
      nxt.pixels_left = left_next;
      nxt.line_active = (left_next != '0);
      pix.pixel_x     = nxt.cur_x;
      pix.pixel_y     = nxt.cur_y;
      pix.last_pixel  = (left_next == '0);
      pix.pixel_valid = 1'b1;
    end
  end

endmodule

// ===== rtl/bresenham_line_points.sv =====
// Bresenham line pixel generator. A start transaction (req_type 0) loads both
// endpoints and returns the first pixel; each next transaction (req_type 1)
// returns the following pixel, with last_pixel set on the final one. A next
// transaction with no line in progress returns pixel_valid 0. The line state
// and the result register are both written at the accepting edge by one
// error-term add and compare, so a new transaction is taken every cycle unless
// a pending result is held by pix_ready low, including while a result waits on
// pix_ready with the result register being emptied in the same cycle. The
// result is registered and shows in the cycle after acceptance.
module bresenham_line_points (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  blp_pkg::blp_req_t req,
  output logic              pix_valid,
  input  logic              pix_ready,
  output blp_pkg::blp_pix_t pix
);
  import blp_pkg::*;

  blp_state_t line_st;
  blp_state_t setup_st;
  blp_state_t walk_st;
  blp_pix_t   setup_pix;
  blp_pix_t   walk_pix;
  logic       req_fire;

  blp_setup u_setup (
    .req (req),
    .st  (setup_st),
    .pix (setup_pix)
  );

  blp_walk u_walk (
    .cur (line_st),
    .nxt (walk_st),
    .pix (walk_pix)
  );

  assign req_ready = !pix_valid || pix_ready;
  assign req_fire  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_st   <= '0;
      pix_valid <= 1'b0;
    end else if (req_fire) begin
      pix_valid <= 1'b1;
      if (req.req_type == REQ_START) begin
        line_st <= setup_st;
      end else begin
        line_st <= walk_st;
      end
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  // result payload, no reset
  always_ff @(posedge clk) begin
    if (req_fire) begin
      pix <= (req.req_type == REQ_START) ? setup_pix : walk_pix;
    end
  end

endmodule

// ===== rtl/blp_checker.sv =====
`include "bresenham_line_points_macros.svh"

module blp_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input blp_pkg::blp_req_t req,
  input logic              pix_valid,
  input logic              pix_ready,
  input blp_pkg::blp_pix_t pix
);
  import blp_pkg::*;

  `BLP_ASSERT_ALWAYS(a_reset_empty, rst |=> !pix_valid, "result pending after reset")
  `BLP_ASSERT(a_pix_hold, pix_valid && !pix_ready |=> pix_valid && $stable(pix), "stalled result changed")
  `BLP_ASSERT(a_one_result, req_valid && req_ready |=> pix_valid, "accepted transaction gave no result")
  `BLP_ASSERT(a_ready_empty, !pix_valid |-> req_ready, "not ready with empty result register")
  `BLP_ASSERT(a_dot_line, req_valid && req_ready && req.req_type == REQ_START && req.x_start == req.x_end && req.y_start == req.y_end |=> pix.last_pixel && pix.pixel_valid && pix.pixel_x == $past(req.x_start) && pix.pixel_y == $past(req.y_start), "single-point line not closed")

endmodule

bind bresenham_line_points blp_checker u_checker (.*);
